/* hdl/fnas_pkg.sv */
// ----------------------------------------------------------------------------
// fnas_pkg
// Shared types and constants for the face normal / area scale pipeline.
// ----------------------------------------------------------------------------
package fnas_pkg;

    localparam int unsigned TAN_W   = 24;  // Q8.16 tangent component
    localparam int unsigned MAG_W   = 48;  // |c| and area, Q16.32
    localparam int unsigned SUM_W   = 96;  // |c|^2, Q32.64
    localparam int unsigned REM_W   = 51;  // square root remainder
    localparam int unsigned QUO_W   = 31;  // |normal| quotient, up to 2^30
    localparam int unsigned NRM_W   = 32;  // Q1.30 output
    localparam int unsigned SQRT_ST = 48;  // one root bit per stage
    localparam int unsigned DIV_ST  = 31;  // one quotient bit per stage

    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic [1:0] DIM_3D = 2'd3;

    localparam logic [0:0] REG_SPACE_DIM = 1'b0;

    // control bits that travel with each beat
    typedef struct packed {
        logic vld;
        logic bend;
        logic unit;  // 1D rule
    } ctl_t;

    // vector data carried down the root pipeline
    typedef struct packed {
        logic [2:0]            sgn;
        logic [2:0][MAG_W-1:0] mag;
    } vec_t;

endpackage

/* hdl/face_normal_and_area_scale.sv */
// ----------------------------------------------------------------------------
// face_normal_and_area_scale
// Surface Jacobian and unit normal per face quadrature point.
// ----------------------------------------------------------------------------
//  channel | handshake                 | beat content
//  --------+---------------------------+----------------------------------
//  in      | in_valid / in_ready       | tangents a, b (Q8.16), batch_end_in
//  out     | out_valid / out_ready     | area_scale, normal_x/y/z, flags
//  cfg     | APB psel/penable/pwrite   | space_dimension at address 0
//
// One beat a cycle in and out while the output is not stalled. The pipeline has
// 5 cross product and squaring stages, 48 square root stages (one root bit each),
// 31 divider stages (one quotient bit each) and the output register.
// Reset clears every valid bit and sets space_dimension to 3.
// The whole pipeline holds while the output register is full and not taken,
// so in_ready falls with it and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module face_normal_and_area_scale (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input beats
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] tangent_a_x,
    input  logic signed [23:0] tangent_a_y,
    input  logic signed [23:0] tangent_a_z,
    input  logic signed [23:0] tangent_b_x,
    input  logic signed [23:0] tangent_b_y,
    input  logic signed [23:0] tangent_b_z,
    input  logic               batch_end_in,
    // output beats
    output logic               out_valid,
    input  logic               out_ready,
    output logic [47:0]        area_scale,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    output logic signed [31:0] normal_z,
    output logic               degenerate,
    output logic               batch_end_out
);
    import fnas_pkg::*;

    logic [1:0] dim_reg;
    logic       en;

    ctl_t             x_ctl, s_ctl, d_ctl;
    vec_t             x_vec, s_vec;
    logic [SUM_W-1:0] x_sum;
    logic [MAG_W-1:0] s_root, d_area;
    logic [2:0]       d_sgn;
    logic [2:0][QUO_W-1:0] d_quo;

    logic                    out_vld_reg;
    logic [MAG_W-1:0]        area_reg;
    logic [2:0][NRM_W-1:0]   nrm_reg;
    logic                    deg_reg, bend_reg;
    logic [2:0][NRM_W-1:0]   nrm_next;

    // register file: one register, indexed by paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPACE_DIM) ? {30'b0, dim_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= DIM_3D;
        else if (psel && penable && pwrite && (paddr[2] == REG_SPACE_DIM))
            dim_reg <= pwdata[1:0];
    end

    // global advance: stall everything while the result waits
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    fnas_cross u_cross (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .dim  (dim_reg),
        .vld  (in_valid),
        .bend (batch_end_in),
        .ax   (tangent_a_x),
        .ay   (tangent_a_y),
        .az   (tangent_a_z),
        .bx   (tangent_b_x),
        .by   (tangent_b_y),
        .bz   (tangent_b_z),
        .ctl  (x_ctl),
        .vec  (x_vec),
        .sum  (x_sum)
    );

    fnas_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (x_ctl),
        .vec_in (x_vec),
        .sum    (x_sum),
        .ctl_out(s_ctl),
        .vec_out(s_vec),
        .root   (s_root)
    );

    fnas_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (s_ctl),
        .vec_in  (s_vec),
        .area_in (s_root),
        .ctl_out (d_ctl),
        .sgn_out (d_sgn),
        .area_out(d_area),
        .quo     (d_quo)
    );

    // restore signs; quotient is at most 2^30 so it fits with a sign bit
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            nrm_next[i] = d_sgn[i] ? -{1'b0, d_quo[i]} : {1'b0, d_quo[i]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d_ctl.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bend_reg <= d_ctl.bend;
            if (d_ctl.unit)
            begin
                // 1D: area 1.0, normal (-1, 0, 0)
                area_reg <= 48'h0001_0000_0000;
                nrm_reg  <= {32'b0, 32'b0, 32'hC000_0000};
                deg_reg  <= 1'b0;
            end
            else if (d_area == '0)
            begin
                area_reg <= '0;
                nrm_reg  <= '0;
                deg_reg  <= 1'b1;
            end
            else
            begin
                area_reg <= d_area;
                nrm_reg  <= nrm_next;
                deg_reg  <= 1'b0;
            end
        end
    end

    assign out_valid     = out_vld_reg;
    assign area_scale    = area_reg;
    assign normal_x      = nrm_reg[0];
    assign normal_y      = nrm_reg[1];
    assign normal_z      = nrm_reg[2];
    assign degenerate    = deg_reg;
    assign batch_end_out = bend_reg;

endmodule

/* hdl/fnas_cross.sv */
// ----------------------------------------------------------------------------
// fnas_cross
// Cross product, component magnitudes and squared length (five stages).
// ----------------------------------------------------------------------------
module fnas_cross (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic [1:0]                       dim,
    input  logic                             vld,
    input  logic                             bend,
    input  logic signed [fnas_pkg::TAN_W-1:0] ax,
    input  logic signed [fnas_pkg::TAN_W-1:0] ay,
    input  logic signed [fnas_pkg::TAN_W-1:0] az,
    input  logic signed [fnas_pkg::TAN_W-1:0] bx,
    input  logic signed [fnas_pkg::TAN_W-1:0] by,
    input  logic signed [fnas_pkg::TAN_W-1:0] bz,
    output fnas_pkg::ctl_t                   ctl,
    output fnas_pkg::vec_t                   vec,
    output logic [fnas_pkg::SUM_W-1:0]       sum
);
    import fnas_pkg::*;

    ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic signed [47:0] p_reg [6];
    logic signed [47:0] p_next [6];
    vec_t vec2_reg, vec3_reg, vec4_reg, vec5_reg;
    logic [47:0] hh_reg [3], hl_reg [3], ll_reg [3];
    logic [SUM_W-1:0] sq_reg [3];
    logic [SUM_W-1:0] sum_reg;
    logic signed [48:0] c [3];

    always_comb
    begin
        if (dim == DIM_3D)
        begin
            p_next[0] = ay * bz;
            p_next[1] = az * by;
            p_next[2] = az * bx;
            p_next[3] = ax * bz;
            p_next[4] = ax * by;
            p_next[5] = ay * bx;
        end
        else
        begin
            // 2D: (ay, -ax) raised to Q16.32
            p_next[0] = signed'({{8{ay[23]}}, ay, 16'b0});
            p_next[1] = '0;
            p_next[2] = '0;
            p_next[3] = signed'({{8{ax[23]}}, ax, 16'b0});
            p_next[4] = '0;
            p_next[5] = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c[i] = {p_reg[2*i][47], p_reg[2*i]} - {p_reg[2*i+1][47], p_reg[2*i+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= '{vld: vld, bend: bend, unit: (dim != DIM_2D) && (dim != DIM_3D)};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
                p_reg[i] <= p_next[i];
            for (int i = 0; i < 3; i++)
            begin
                vec2_reg.sgn[i] <= c[i][48];
                vec2_reg.mag[i] <= c[i][48] ? 48'(-c[i]) : c[i][47:0];
                hh_reg[i] <= vec2_reg.mag[i][47:24] * vec2_reg.mag[i][47:24];
                hl_reg[i] <= vec2_reg.mag[i][47:24] * vec2_reg.mag[i][23:0];
                ll_reg[i] <= vec2_reg.mag[i][23:0] * vec2_reg.mag[i][23:0];
                sq_reg[i] <= {hh_reg[i], 48'b0} + {23'b0, hl_reg[i], 25'b0}
                           + {48'b0, ll_reg[i]};
            end
            vec3_reg <= vec2_reg;
            vec4_reg <= vec3_reg;
            vec5_reg <= vec4_reg;
            sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign ctl = ctl5_reg;
    assign vec = vec5_reg;
    assign sum = sum_reg;

endmodule

/* hdl/fnas_sqrt.sv */
// ----------------------------------------------------------------------------
// fnas_sqrt
// Floor square root, restoring digit recurrence, one root bit per stage.
// ----------------------------------------------------------------------------
module fnas_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  fnas_pkg::ctl_t             ctl_in,
    input  fnas_pkg::vec_t             vec_in,
    input  logic [fnas_pkg::SUM_W-1:0] sum,
    output fnas_pkg::ctl_t             ctl_out,
    output fnas_pkg::vec_t             vec_out,
    output logic [fnas_pkg::MAG_W-1:0] root
);
    import fnas_pkg::*;

    ctl_t             ctl_reg  [SQRT_ST];
    vec_t             vec_reg  [SQRT_ST];
    logic [SUM_W-1:0] s_reg    [SQRT_ST];
    logic [REM_W-1:0] rem_reg  [SQRT_ST];
    logic [MAG_W-1:0] root_reg [SQRT_ST];

    for (genvar k = 0; k < SQRT_ST; k++)
    begin : g_stage
        ctl_t             c_in;
        vec_t             v_in;
        logic [SUM_W-1:0] s_in;
        logic [REM_W-1:0] rem_in, rem_t, trial;
        logic [MAG_W-1:0] root_in;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign c_in    = ctl_in;
            assign v_in    = vec_in;
            assign s_in    = sum;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign c_in    = ctl_reg[k-1];
            assign v_in    = vec_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign rem_t = {rem_in[REM_W-3:0], s_in[SUM_W-1:SUM_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = rem_t >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (en)
                ctl_reg[k] <= c_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vec_reg[k]  <= v_in;
                s_reg[k]    <= {s_in[SUM_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? rem_t - trial : rem_t;
                root_reg[k] <= {root_in[MAG_W-2:0], ge};
            end
        end
    end

    assign ctl_out = ctl_reg[SQRT_ST-1];
    assign vec_out = vec_reg[SQRT_ST-1];
    assign root    = root_reg[SQRT_ST-1];

endmodule

/* hdl/fnas_div.sv */
// ----------------------------------------------------------------------------
// fnas_div
// Three-lane restoring divider, |c| * 2^30 / area, one quotient bit a stage.
// ----------------------------------------------------------------------------
module fnas_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  fnas_pkg::ctl_t             ctl_in,
    input  fnas_pkg::vec_t             vec_in,
    input  logic [fnas_pkg::MAG_W-1:0] area_in,
    output fnas_pkg::ctl_t             ctl_out,
    output logic [2:0]                 sgn_out,
    output logic [fnas_pkg::MAG_W-1:0] area_out,
    output logic [2:0][fnas_pkg::QUO_W-1:0] quo
);
    import fnas_pkg::*;

    ctl_t             ctl_reg  [DIV_ST];
    logic [2:0]       sgn_reg  [DIV_ST];
    logic [MAG_W-1:0] d_reg    [DIV_ST];
    logic [2:0][MAG_W:0]   r_reg [DIV_ST];
    logic [2:0][QUO_W-1:0] q_reg [DIV_ST];

    for (genvar k = 0; k < DIV_ST; k++)
    begin : g_stage
        ctl_t                  c_in;
        logic [2:0]            s_in;
        logic [MAG_W-1:0]      d_in;
        logic [2:0][MAG_W:0]   r_in, r_t, r_n;
        logic [2:0][QUO_W-1:0] q_in, q_n;

        if (k == 0)
        begin : g_first
            assign c_in = ctl_in;
            assign s_in = vec_in.sgn;
            assign d_in = area_in;
            for (genvar j = 0; j < 3; j++)
            begin : g_ld
                assign r_in[j] = {1'b0, vec_in.mag[j]};
                assign r_t[j]  = r_in[j];
            end
            assign q_in = '0;
        end
        else
        begin : g_next
            assign c_in = ctl_reg[k-1];
            assign s_in = sgn_reg[k-1];
            assign d_in = d_reg[k-1];
            assign r_in = r_reg[k-1];
            assign q_in = q_reg[k-1];
            for (genvar j = 0; j < 3; j++)
            begin : g_sh
                assign r_t[j] = {r_in[j][MAG_W-1:0], 1'b0};
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic ge;
            assign ge     = r_t[j] >= {1'b0, d_in};
            assign r_n[j] = ge ? r_t[j] - {1'b0, d_in} : r_t[j];
            assign q_n[j] = {q_in[j][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (en)
                ctl_reg[k] <= c_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sgn_reg[k] <= s_in;
                d_reg[k]   <= d_in;
                r_reg[k]   <= r_n;
                q_reg[k]   <= q_n;
            end
        end
    end

    assign ctl_out  = ctl_reg[DIV_ST-1];
    assign sgn_out  = sgn_reg[DIV_ST-1];
    assign area_out = d_reg[DIV_ST-1];
    assign quo      = q_reg[DIV_ST-1];

endmodule
